// ----- hdl/dequ_pkg.sv -----
// Shared types and opcode constants for the double-ended queue unit.
`default_nettype none

package dequ_pkg;

  localparam int OPCODE_W = 3;
  localparam int WORD_W = 32;
  localparam int LENGTH_W = 5;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [WORD_W-1:0]   value;
  } dequ_req_t;

  typedef struct packed {
    logic                ok;
    logic [WORD_W-1:0]   read_value;
    logic [LENGTH_W-1:0] length;
  } dequ_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
  } dequ_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
  } dequ_stat_t;

endpackage

`default_nettype wire

// ----- hdl/dequ_ctrl.sv -----
// Controller state machine for the double-ended queue unit.
`default_nettype none

module dequ_ctrl
  import dequ_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  output dequ_cmd_t       cmd,
  input  wire dequ_stat_t stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the result register to free up
        if (stat.slot_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dequ_datapath.sv -----
// Datapath of the double-ended queue unit: pointers, entry memory, result register.
`default_nettype none

module dequ_datapath
  import dequ_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dequ_req_t req,
  input  wire dequ_cmd_t cmd,
  output dequ_stat_t     stat,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output dequ_rsp_t      rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          pend_rd;
  logic          pend_ok;

  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW:0]   back_sum;
  logic [AW:0]   last_sum;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] last_slot_idx;
  logic          op_ok;
  logic          op_rd;
  logic          op_we;
  logic [AW-1:0] addr;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);

  assign head_dec = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + AW'(1);

  // wrap head + offset back into the buffer; sum stays below twice the depth
  assign back_sum  = (AW + 1)'(head) + (AW + 1)'(count);
  assign last_sum  = back_sum - (AW + 1)'(1);
  assign back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign last_slot_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  always_comb begin
    op_ok      = 1'b0;
    op_rd      = 1'b0;
    op_we      = 1'b0;
    addr       = head;
    head_next  = head;
    count_next = count;
    case (req.opcode)
      OP_PUSH_FRONT: begin
        op_ok = !full;
        op_we = !full;
        addr  = head_dec;
        if (!full) begin
          head_next  = head_dec;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        op_ok = !full;
        op_we = !full;
        addr  = back_slot;
        if (!full) begin
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        op_ok = !empty;
        op_rd = !empty;
        addr  = head;
        if (!empty && req.opcode == OP_POP_FRONT) begin
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        op_ok = !empty;
        op_rd = !empty;
        addr  = last_slot_idx;
        if (!empty && req.opcode == OP_POP_BACK) begin
          count_next = count - CW'(1);
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && op_we) begin
      mem[addr] <= req.value[SW-1:0];
    end
    if (cmd.accept && op_rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_ok <= op_ok;
      pend_rd <= op_rd;
    end
  end

  assign stat.slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.ok         <= pend_ok;
      rsp.read_value <= pend_rd ? WORD_W'(rdata) : '0;
      rsp.length     <= LENGTH_W'(count);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/double_ended_queue_unit.sv -----
// A request is taken in the idle state; the load state then waits for the output
// register to free up and loads the result. The entry memory read is registered; no
// new request is taken until the result of the last one is loaded.
// A finished result waits in the output register while the next request is taken.
// Reset clears head, count and the valid flag; entry contents are not cleared.
`default_nettype none

module double_ended_queue_unit
  import dequ_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire dequ_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output dequ_rsp_t      rsp
);

  dequ_cmd_t  cmd;
  dequ_stat_t stat;

  dequ_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  dequ_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- tb/double_ended_queue_unit_tb.sv -----
// Self-checking testbench for the double-ended queue unit with a shadow deque predictor.
module double_ended_queue_unit_tb;
  import dequ_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 80;

  // Opcodes the block ignores
  localparam logic [OPCODE_W-1:0] OP_RESERVED_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RESERVED_B = 3'd7;

  // Bias of a random segment
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} seg_mode_t;

  typedef struct {
    dequ_req_t req;
    bit        wait_drain;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  dequ_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  dequ_rsp_t rsp;

  queued_req_t req_backlog[$];
  dequ_rsp_t   due_responses[$];

  // Shadow copy of the deque contents
  logic [WORD_W-1:0]   shadow_words[DEPTH];
  logic [3:0]          shadow_head = '0;
  logic [LENGTH_W-1:0] shadow_count = '0;

  int  req_accepts = 0;
  int  req_issued = 0;
  int  mismatches = 0;
  int  calm_from = 32'h7fffffff;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  long_hold_done = 1'b0;
  logic calm;
  queued_req_t next_req;
  dequ_rsp_t   want;

  assign calm = (req_accepts >= calm_from);

  double_ended_queue_unit #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(WORD_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow deque and return the response it yields.
  function automatic dequ_rsp_t deque_apply(dequ_req_t r);
    dequ_rsp_t  o;
    logic [3:0] tail_idx;
    o = '0;
    tail_idx = shadow_head + 4'(shadow_count - 1'b1);
    case (r.opcode)
      OP_PUSH_FRONT: begin
        if (shadow_count < DEPTH) begin
          shadow_head = shadow_head - 1'b1;
          shadow_words[shadow_head] = r.value;
          shadow_count = shadow_count + 1'b1;
          o.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count < DEPTH) begin
          shadow_words[shadow_head + shadow_count[3:0]] = r.value;
          shadow_count = shadow_count + 1'b1;
          o.ok = 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (shadow_count != 0) begin
          o.ok = 1'b1;
          o.read_value = shadow_words[shadow_head];
          if (r.opcode == OP_POP_FRONT) begin
            shadow_head = shadow_head + 1'b1;
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (shadow_count != 0) begin
          o.ok = 1'b1;
          o.read_value = shadow_words[tail_idx];
          if (r.opcode == OP_POP_BACK) shadow_count = shadow_count - 1'b1;
        end
      end
      default: ;
    endcase
    o.length = shadow_count;
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [OPCODE_W-1:0] rand_op(seg_mode_t mode);
    int roll;
    int push_pct;
    roll = $urandom_range(99);
    push_pct = (mode == MODE_GROW) ? 72 : (mode == MODE_SHRINK) ? 25 : 48;
    if (roll < 3) return (roll == 0) ? OP_RESERVED_A : OP_RESERVED_B;
    if (roll < 3 + push_pct) return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    case ($urandom_range(9))
      0, 1, 2, 3: return OP_POP_FRONT;
      4, 5, 6:    return OP_POP_BACK;
      7:          return OP_PEEK_FRONT;
      default:    return OP_PEEK_BACK;
    endcase
  endfunction

  task automatic add_item(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] word, bit wait_drain);
    queued_req_t q;
    q.req.opcode = op;
    q.req.value = word;
    q.wait_drain = wait_drain;
    req_backlog.push_back(q);
  endtask

  // Driver: offer the next backlog item when the bus is free, with random gaps and drain waits.
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_accepts == req_issued)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        req_valid <= 1'b0;
      end else if (req_backlog[0].wait_drain && due_responses.size() != 0) begin
        req_valid <= 1'b0;
      end else if (!calm && $urandom_range(7) == 0) begin
        gap_left = $urandom_range(7, 1) - 1;
        req_valid <= 1'b0;
      end else begin
        next_req = req_backlog.pop_front();
        req <= next_req.req;
        req_valid <= 1'b1;
        req_issued++;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (!rst) begin
      if (!long_hold_done && req_accepts >= 400) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(9) == 0) begin
        stall_left = $urandom_range(7, 1) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Monitor: check each response transfer, then predict from each request transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (due_responses.size() == 0) begin
          $error("unexpected response: ok=%0d read_value=%h length=%0d",
                 rsp.ok, rsp.read_value, rsp.length);
          mismatches++;
        end else begin
          want = due_responses.pop_front();
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
            mismatches++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
            mismatches++;
          end
          if (rsp.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, rsp.length);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        due_responses.push_back(deque_apply(req));
        req_accepts <= req_accepts + 1;
      end
    end
  end

  // Watchdog on cycles with no request transfer
  always @(posedge clk) begin
    if (req_valid && !req_stall) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int        k;
    int        seg_len;
    int        total_items;
    bit        drain_placed;
    seg_mode_t mode;

    drain_placed = 1'b0;

    // Reads on the empty queue fail; then pushes, peeks, reserved opcodes and pops
    add_item(OP_POP_FRONT, '1, 1'b0);
    add_item(OP_POP_BACK, '1, 1'b0);
    add_item(OP_PEEK_FRONT, '0, 1'b0);
    add_item(OP_PEEK_BACK, '0, 1'b0);
    add_item(OP_PUSH_FRONT, '0, 1'b0);
    add_item(OP_PUSH_BACK, '1, 1'b0);
    add_item(OP_PUSH_FRONT, 32'ha5a5_a5a5, 1'b0);
    add_item(OP_PUSH_BACK, 32'h5a5a_5a5a, 1'b0);
    add_item(OP_PEEK_FRONT, '0, 1'b0);
    add_item(OP_PEEK_BACK, '0, 1'b0);
    add_item(OP_RESERVED_A, '1, 1'b0);
    add_item(OP_RESERVED_B, '0, 1'b0);
    add_item(OP_POP_BACK, '0, 1'b0);
    add_item(OP_POP_FRONT, '0, 1'b0);
    add_item(OP_POP_BACK, '0, 1'b0);
    add_item(OP_POP_FRONT, '0, 1'b0);
    add_item(OP_PEEK_BACK, '1, 1'b0);

    // Fill to the brim, push onto a full queue, then drain past empty
    for (k = 0; k < DEPTH + 2; k++)
      add_item($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word(), 1'b0);
    add_item(OP_PEEK_FRONT, rand_word(), 1'b0);
    add_item(OP_PEEK_BACK, rand_word(), 1'b0);
    for (k = 0; k < DEPTH + 2; k++)
      add_item($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, rand_word(), 1'b0);

    while (req_backlog.size() < 1100) begin
      mode = seg_mode_t'($urandom_range(2));
      seg_len = $urandom_range(40, 8);
      for (k = 0; k < seg_len; k++) begin
        add_item(rand_op(mode), rand_word(),
                 k == 0 && !drain_placed && req_backlog.size() >= 550);
        if (req_backlog[$].wait_drain) drain_placed = 1'b1;
      end
    end

    total_items = req_backlog.size();
    calm_from = total_items - 120;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (req_accepts < total_items) @(posedge clk);
    while (due_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dequ_pkg.sv
hdl/dequ_ctrl.sv
hdl/dequ_datapath.sv
hdl/double_ended_queue_unit.sv
tb/double_ended_queue_unit_tb.sv
